[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AOLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AOLI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define AOLI_ASSERT_NXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/aoli_pkg.sv]
// Types, constants and the arctangent table of the atan2 block.
package aoli_pkg;

    localparam int MAG_W  = 16;              // magnitude and remainder width
    localparam int QUO_W  = 11;              // ratio width, 0..1024
    localparam int FRAC_W = 4;               // interpolation fraction bits
    localparam int IDX_W  = QUO_W - FRAC_W;  // table index width
    localparam int ROM_W  = 14;              // table entry width, up to 0x2000
    localparam int DLT_W  = 8;               // step between neighbor entries
    localparam int ANG_W  = 16;              // output angle width
    localparam int NUM_CELLS = QUO_W;        // one divider cell per ratio bit

    localparam logic [ROM_W-1:0] ROM_FULL = 14'h2000;  // 45 degrees

    // Quadrant base codes: the table result is added to or subtracted from base * 16384
    localparam logic [1:0] BASE_0   = 2'd0;
    localparam logic [1:0] BASE_90  = 2'd1;
    localparam logic [1:0] BASE_180 = 2'd2;
    localparam logic [1:0] BASE_270 = 2'd3;

    typedef struct packed {
        logic [1:0] base;   // quadrant base code
        logic       neg;    // subtract the table angle from the base
    } oct_t;

    // Data handed from one divider cell to the next
    typedef struct packed {
        logic             vld;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] quo;
        oct_t             oct;
    } cell_data_t;

    // Arctangent of idx/64 for idx 0..64, 0x2000 = 45 degrees
    function automatic logic [ROM_W-1:0] atan_rom(input logic [IDX_W-1:0] idx);
        logic [ROM_W-1:0] val;
        case (idx)
            7'd0:  val = 14'h0000;  7'd1:  val = 14'h00A3;
            7'd2:  val = 14'h0146;  7'd3:  val = 14'h01E9;
            7'd4:  val = 14'h028B;  7'd5:  val = 14'h032D;
            7'd6:  val = 14'h03CF;  7'd7:  val = 14'h0470;
            7'd8:  val = 14'h0511;  7'd9:  val = 14'h05B1;
            7'd10: val = 14'h0651;  7'd11: val = 14'h06EF;
            7'd12: val = 14'h078D;  7'd13: val = 14'h082A;
            7'd14: val = 14'h08C6;  7'd15: val = 14'h0961;
            7'd16: val = 14'h09FB;  7'd17: val = 14'h0A94;
            7'd18: val = 14'h0B2C;  7'd19: val = 14'h0BC2;
            7'd20: val = 14'h0C57;  7'd21: val = 14'h0CEB;
            7'd22: val = 14'h0D7D;  7'd23: val = 14'h0E0F;
            7'd24: val = 14'h0E9E;  7'd25: val = 14'h0F2C;
            7'd26: val = 14'h0FB9;  7'd27: val = 14'h1044;
            7'd28: val = 14'h10CE;  7'd29: val = 14'h1156;
            7'd30: val = 14'h11DC;  7'd31: val = 14'h1261;
            7'd32: val = 14'h12E4;  7'd33: val = 14'h1366;
            7'd34: val = 14'h13E6;  7'd35: val = 14'h1464;
            7'd36: val = 14'h14E0;  7'd37: val = 14'h155B;
            7'd38: val = 14'h15D5;  7'd39: val = 14'h164C;
            7'd40: val = 14'h16C2;  7'd41: val = 14'h1737;
            7'd42: val = 14'h17AA;  7'd43: val = 14'h181B;
            7'd44: val = 14'h188A;  7'd45: val = 14'h18F8;
            7'd46: val = 14'h1964;  7'd47: val = 14'h19CF;
            7'd48: val = 14'h1A38;  7'd49: val = 14'h1A9F;
            7'd50: val = 14'h1B05;  7'd51: val = 14'h1B6A;
            7'd52: val = 14'h1BCD;  7'd53: val = 14'h1C2E;
            7'd54: val = 14'h1C8E;  7'd55: val = 14'h1CED;
            7'd56: val = 14'h1D4A;  7'd57: val = 14'h1DA5;
            7'd58: val = 14'h1DFF;  7'd59: val = 14'h1E58;
            7'd60: val = 14'h1EB0;  7'd61: val = 14'h1F06;
            7'd62: val = 14'h1F5A;  7'd63: val = 14'h1FAE;
            default: val = ROM_FULL;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/aoli_div_cell.sv]
// One restoring-division cell: resolves one ratio bit per transaction.
module aoli_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  aoli_pkg::cell_data_t d_in,
    output aoli_pkg::cell_data_t d_out
);
    import aoli_pkg::*;

    logic             vld_reg;
    cell_data_t       pay_reg;
    cell_data_t       pay_next;
    logic             take;
    logic [MAG_W-1:0] diff;

    // Trial subtract; remainder stays below the divisor, so the shift fits
    always_comb begin
        take     = (d_in.rem >= d_in.den);
        diff     = take ? (d_in.rem - d_in.den) : d_in.rem;
        pay_next = d_in;
        pay_next.rem = {diff[MAG_W-2:0], 1'b0};
        pay_next.quo = {d_in.quo[QUO_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= d_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg <= pay_next;
        end
    end

    always_comb begin
        d_out     = pay_reg;
        d_out.vld = vld_reg;
    end

endmodule

[hw/rtl/aoli_interp.sv]
// Table lookup, linear interpolation and octant mapping; holds the output register.
module aoli_interp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  aoli_pkg::cell_data_t        d_in,
    output logic                        out_valid,
    output logic [aoli_pkg::ANG_W-1:0]  out_angle
);
    import aoli_pkg::*;

    logic              vld_a_reg;
    logic [ROM_W-1:0]  base_a_reg, base_a_next;
    logic [DLT_W-1:0]  dlt_a_reg, dlt_a_next;
    logic [FRAC_W-1:0] frac_a_reg;
    oct_t              oct_a_reg;

    logic              vld_b_reg;
    logic [ANG_W-1:0]  ang_b_reg, ang_b_next;

    logic [IDX_W-1:0]  idx;
    logic [ROM_W-1:0]  rom_hi;
    logic [ROM_W-1:0]  rom_step;
    logic [DLT_W+FRAC_W-1:0] prod;
    logic [ROM_W-1:0]  tbl;
    logic [ANG_W-1:0]  tbl_ext;
    logic [ANG_W-1:0]  base_ang;

    // Stage A: read entry and its neighbor; full-scale ratio reads the last entry flat
    always_comb begin
        idx         = d_in.quo[QUO_W-1:FRAC_W];
        rom_hi      = atan_rom(IDX_W'(idx + 1'b1));
        base_a_next = atan_rom(idx);
        rom_step    = rom_hi - base_a_next;
        dlt_a_next  = rom_step[DLT_W-1:0];
        if (idx[IDX_W-1]) begin
            base_a_next = ROM_FULL;
            dlt_a_next  = '0;
        end
    end

    // Stage B: interpolate, then add or subtract from the quadrant base mod 2^16
    always_comb begin
        prod     = dlt_a_reg * frac_a_reg;
        tbl      = base_a_reg + ROM_W'(prod[DLT_W+FRAC_W-1:FRAC_W]);
        tbl_ext  = {{(ANG_W-ROM_W){1'b0}}, tbl};
        base_ang = {oct_a_reg.base, {(ANG_W-2){1'b0}}};
        ang_b_next = oct_a_reg.neg ? (base_ang - tbl_ext) : (base_ang + tbl_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= d_in.vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base_a_reg <= base_a_next;
            dlt_a_reg  <= dlt_a_next;
            frac_a_reg <= d_in.quo[FRAC_W-1:0];
            oct_a_reg  <= d_in.oct;
            ang_b_reg  <= ang_b_next;
        end
    end

    assign out_valid = vld_b_reg;
    assign out_angle = ang_b_reg;

endmodule

[hw/rtl/atan2_octant_lut_interpolated.sv]
// Pipeline: front stage, 11 divider cells, 2 table stages from input transaction to result.
// Throughput: one transaction per cycle unless stalled; the divider chain takes a new ratio every cycle.
// The whole pipeline advances while the output register is empty or being taken.
// Reset: synchronous, active low; clears the valid bits of every stage, data is not reset.
module atan2_octant_lut_interpolated (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_x_component,
    input  logic signed [15:0] s_y_component,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_angle
);
    import aoli_pkg::*;

    logic                 adv;
    logic [MAG_W:0]       xs, ys, ax_w, ay_w;
    logic [MAG_W-1:0]     ax, ay, axc, ayc;
    logic                 ge;
    oct_t                 oct;
    logic                 front_vld_reg;
    cell_data_t           front_pay_reg, front_next;
    cell_data_t           chain [0:NUM_CELLS];

    // Global advance: output register empty or being taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Front: magnitudes, clamp, octant decision on the raw magnitudes
    always_comb begin
        xs   = {s_x_component[15], s_x_component};
        ys   = {s_y_component[15], s_y_component};
        ax_w = s_x_component[15] ? ((MAG_W+1)'(0) - xs) : xs;
        ay_w = s_y_component[15] ? ((MAG_W+1)'(0) - ys) : ys;
        ax   = ax_w[MAG_W-1:0];
        ay   = ay_w[MAG_W-1:0];
        axc  = (ax == '0) ? MAG_W'(1) : ax;
        ayc  = (ay == '0) ? MAG_W'(1) : ay;
        ge   = (ax >= ay);

        case ({s_x_component[15], s_y_component[15]})
            2'b00:   begin oct.base = ge ? BASE_0   : BASE_90;  oct.neg = !ge; end
            2'b01:   begin oct.base = ge ? BASE_0   : BASE_270; oct.neg = ge;  end
            2'b10:   begin oct.base = ge ? BASE_180 : BASE_90;  oct.neg = ge;  end
            default: begin oct.base = ge ? BASE_180 : BASE_270; oct.neg = !ge; end
        endcase

        front_next.vld = s_valid;
        front_next.rem = ge ? ayc : axc;
        front_next.den = ge ? axc : ayc;
        front_next.quo = '0;
        front_next.oct = oct;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= 1'b0;
        end else if (adv) begin
            front_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            front_pay_reg <= front_next;
        end
    end

    always_comb begin
        chain[0]     = front_pay_reg;
        chain[0].vld = front_vld_reg;
    end

    // Divider chain: one cell per ratio bit, MSB first
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        aoli_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .d_in    (chain[i]),
            .d_out   (chain[i+1])
        );
    end

    aoli_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .d_in      (chain[NUM_CELLS]),
        .out_valid (m_valid),
        .out_angle (m_angle)
    );

endmodule

[hw/rtl/aoli_checker.sv]
// Port-level checker for the atan2 block and its bind statement.
`include "assert_macros.svh"

module aoli_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [15:0] s_x_component,
    input logic [15:0] s_y_component,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_angle
);
    // Reset empties the output
    `AOLI_ASSERT_NXT_NR(a_rst_empty, aclk, !aresetn, !m_valid)
    // A stalled result holds its value
    `AOLI_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_angle))
    // Input is taken whenever the output side moves
    `AOLI_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_valid || m_ready, s_ready)
    // Input is held off while a result is stalled
    `AOLI_ASSERT_IMP(a_ready_stall, aclk, aresetn, m_valid && !m_ready, !s_ready)
endmodule

bind atan2_octant_lut_interpolated aoli_checker u_aoli_checker (.*);

[tb/atan2_octant_lut_interpolated_test.sv]
// Testbench for the atan2 block: directed and random vectors checked against a table predictor.
`timescale 1ns / 100ps

localparam int unsigned ANGLE_QUARTER       = 32'd16384;
localparam int unsigned ANGLE_HALF          = 32'd32768;
localparam int unsigned ANGLE_THREE_QUARTER = 32'd49152;
localparam int unsigned ANGLE_OCTANT        = 32'h2000;
localparam int unsigned RATIO_SHIFT         = 10;
localparam int unsigned FRAC_MASK           = 32'hF;
localparam int unsigned LAST_STEP           = 64;

// One pending angle, with the sample that produced it
typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        angle;
} angle_entry_t;

class angle_scoreboard;
    angle_entry_t pending_angles[$];
    int           errors;
    logic [15:0]  arc_steps [0:64];

    function new();
        errors = 0;
        // arctangent of k/64, 0x2000 = 45 degrees
        arc_steps = '{
            16'h0000, 16'h00A3, 16'h0146, 16'h01E9, 16'h028B, 16'h032D, 16'h03CF, 16'h0470,
            16'h0511, 16'h05B1, 16'h0651, 16'h06EF, 16'h078D, 16'h082A, 16'h08C6, 16'h0961,
            16'h09FB, 16'h0A94, 16'h0B2C, 16'h0BC2, 16'h0C57, 16'h0CEB, 16'h0D7D, 16'h0E0F,
            16'h0E9E, 16'h0F2C, 16'h0FB9, 16'h1044, 16'h10CE, 16'h1156, 16'h11DC, 16'h1261,
            16'h12E4, 16'h1366, 16'h13E6, 16'h1464, 16'h14E0, 16'h155B, 16'h15D5, 16'h164C,
            16'h16C2, 16'h1737, 16'h17AA, 16'h181B, 16'h188A, 16'h18F8, 16'h1964, 16'h19CF,
            16'h1A38, 16'h1A9F, 16'h1B05, 16'h1B6A, 16'h1BCD, 16'h1C2E, 16'h1C8E, 16'h1CED,
            16'h1D4A, 16'h1DA5, 16'h1DFF, 16'h1E58, 16'h1EB0, 16'h1F06, 16'h1F5A, 16'h1FAE,
            16'h2000
        };
    endfunction

    // Angle of num/den within one octant, interpolated on the low ratio bits
    function int unsigned octant_arc(int unsigned num, int unsigned den);
        int unsigned ratio;
        int unsigned step;
        int unsigned lo;
        int unsigned span;
        ratio = (num << RATIO_SHIFT) / den;
        step  = ratio >> 4;
        if (step >= LAST_STEP)
            return ANGLE_OCTANT;
        lo   = 32'(arc_steps[step]);
        span = 32'(arc_steps[step + 1]) - lo;
        return lo + ((span * (ratio & FRAC_MASK)) >> 4);
    endfunction

    function logic [15:0] predict_angle(logic signed [15:0] x, logic signed [15:0] y);
        int          xs;
        int          ys;
        int unsigned ax;
        int unsigned ay;
        int unsigned turn;
        xs = int'(x);
        ys = int'(y);
        ax = (xs < 0) ? -xs : xs;
        ay = (ys < 0) ? -ys : ys;
        // zero magnitudes are clamped to one
        if (ax == 0) ax = 1;
        if (ay == 0) ay = 1;
        // octant selection; ties take the first branch
        if (xs >= 0) begin
            if (ys >= 0) begin
                if (xs >= ys) turn = octant_arc(ay, ax);
                else          turn = ANGLE_QUARTER - octant_arc(ax, ay);
            end else begin
                if (xs >= -ys) turn = 0 - octant_arc(ay, ax);
                else           turn = ANGLE_THREE_QUARTER + octant_arc(ax, ay);
            end
        end else begin
            if (ys >= 0) begin
                if (-xs >= ys) turn = ANGLE_HALF - octant_arc(ay, ax);
                else           turn = ANGLE_QUARTER + octant_arc(ax, ay);
            end else begin
                if (xs <= ys) turn = ANGLE_HALF + octant_arc(ay, ax);
                else          turn = ANGLE_THREE_QUARTER - octant_arc(ax, ay);
            end
        end
        return turn[15:0];
    endfunction

    task report(string msg);
        errors++;
        $display("%s", msg);
    endtask

    // Input transaction accepted: queue its angle
    function void note_sample(logic signed [15:0] x, logic signed [15:0] y);
        angle_entry_t e;
        e.x     = x;
        e.y     = y;
        e.angle = predict_angle(x, y);
        pending_angles.push_back(e);
    endfunction

    // Result transaction accepted: compare with the oldest pending angle
    task check_angle(logic [15:0] got);
        angle_entry_t e;
        if (pending_angles.size() == 0) begin
            report($sformatf("unexpected angle %h", got));
        end else begin
            e = pending_angles.pop_front();
            if (got !== e.angle)
                report($sformatf("angle %h, predicted %h for x=%0d y=%0d",
                                 got, e.angle, e.x, e.y));
        end
    endtask

    task flush_leftovers();
        while (pending_angles.size() != 0) begin
            angle_entry_t e;
            e = pending_angles.pop_front();
            report($sformatf("missing angle %h for x=%0d y=%0d", e.angle, e.x, e.y));
        end
    endtask
endclass

module atan2_octant_lut_interpolated_test;

    localparam int STALL_LIMIT   = 500;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int QUIET_FROM    = 1300;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_x_component = '0;
    logic signed [15:0] s_y_component = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_angle;

    logic            idling_on = 1'b1;
    int              quiet_cycles = 0;
    angle_scoreboard sb;

    atan2_octant_lut_interpolated uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_component (s_x_component),
        .s_y_component (s_y_component),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_angle       (m_angle)
    );

    always #5 aclk = ~aclk;

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_angle(m_angle);
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("atan2_octant_lut_interpolated: mismatch");
            $finish;
        end
    end

    // Receiver: ready, with random stall bursts while idling is on
    initial begin
        @(posedge aresetn);
        @(negedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Drive one sample, optionally after a short gap; returns at the next falling edge
    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_x_component <= x;
        s_y_component <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(x, y);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] edge_value();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    initial begin
        int                 n;
        int                 mag;
        int                 dev;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] tmp;

        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: origin, axes, full scale, ties, extreme ratios
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0);      send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, 16'sd32767);      send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd0, -16'sd1);         send_sample(-16'sd1, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768); send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767); send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd1, 16'sd1);          send_sample(-16'sd1, 16'sd1);
        send_sample(16'sd1, -16'sd1);         send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd1000, 16'sd1000);    send_sample(-16'sd1000, 16'sd1000);
        send_sample(16'sd1000, -16'sd1000);   send_sample(-16'sd1000, -16'sd1000);
        send_sample(16'sd1000, 16'sd999);     send_sample(16'sd32767, 16'sd1);
        send_sample(16'sd1, 16'sd32767);      send_sample(-16'sd32768, -16'sd32767);
        send_sample(-16'sd32767, -16'sd32768);

        // Random part; the tail runs with no idling on either side
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == QUIET_FROM)
                idling_on = 1'b0;
            case ($urandom_range(0, 7))
                0, 1, 2: begin
                    rx = 16'($urandom);
                    ry = 16'($urandom);
                end
                3: begin
                    rx = 16'($urandom_range(0, 40) - 20);
                    ry = 16'($urandom_range(0, 40) - 20);
                end
                4: begin
                    rx = 16'($urandom);
                    ry = 16'($urandom_range(0, 2) - 1);
                end
                5: begin
                    // near the octant boundary
                    mag = $urandom_range(1, 32767);
                    dev = mag + $urandom_range(0, 6) - 3;
                    if (dev > 32767) dev = 32767;
                    if (dev < 0) dev = 0;
                    rx = 16'($urandom_range(0, 1) ? mag : -mag);
                    ry = 16'($urandom_range(0, 1) ? dev : -dev);
                    if ($urandom_range(0, 15) == 0) ry = (ry < 0) ? -16'sd32768 : 16'sd32767;
                end
                6: begin
                    rx = edge_value();
                    ry = edge_value();
                end
                default: begin
                    rx = 16'($urandom);
                    ry = 16'($urandom_range(0, 15) - 8);
                end
            endcase
            if ($urandom_range(0, 1)) begin
                tmp = rx;
                rx  = ry;
                ry  = tmp;
            end
            send_sample(rx, ry);
        end
        s_valid <= 1'b0;

        // Drain, then allow for late or extra results
        while (sb.pending_angles.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.flush_leftovers();
        if (sb.errors == 0)
            $display("atan2_octant_lut_interpolated: match");
        else
            $display("atan2_octant_lut_interpolated: mismatch");
        $finish;
    end

endmodule
